// ----- hw/rtl/bdq_pkg.sv -----
`timescale 1ns / 1ps

package bdq_pkg;

    // Store geometry; the ring wraps by truncation, so the depth is a power of two.
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int WORD_W = 32;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(DEPTH);

    // Operation codes.
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_QUERY      = 3'd4;

    // Word reported for front and rear when the queue is empty.
    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

    // Configuration handed from the register block to the datapath.
    typedef struct packed {
        logic [CNT_W-1:0] eff_capacity;
    } bdq_cfg_t;

endpackage

// ----- hw/rtl/bdq_op_if.sv -----
`timescale 1ns / 1ps

interface bdq_op_if;
    import bdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [2:0]               op;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink (input valid, input op, input value, output ready);
endinterface

// ----- hw/rtl/bdq_res_if.sv -----
`timescale 1ns / 1ps

interface bdq_res_if;
    import bdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     success;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;
    logic                     is_full;

    modport source (
        output valid, output success, output front_value, output rear_value,
        output entry_count, output is_empty, output is_full, input ready
    );
    modport sink (
        input valid, input success, input front_value, input rear_value,
        input entry_count, input is_empty, input is_full, output ready
    );
endinterface

// ----- hw/rtl/bdq_cfg.sv -----
`timescale 1ns / 1ps

module bdq_cfg
    import bdq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output bdq_cfg_t              cfg
);

    logic [CNT_W-1:0] capacity_reg;
    logic             reg_sel;
    logic             wr_en;

    // Register index is the byte address divided by four.
    assign reg_sel = (paddr[2] == REG_CAPACITY);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready && reg_sel;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (wr_en)
        begin
            capacity_reg <= pwdata[CNT_W-1:0];
        end
    end

    // Read data.
    assign prdata = reg_sel ? APB_DATA_W'(capacity_reg) : '0;

    // A capacity above the store depth acts as the depth.
    assign cfg.eff_capacity = (capacity_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity_reg;

endmodule

// ----- hw/rtl/bounded_double_ended_queue_unit.sv -----
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit words.
// The op channel carries one operation per transfer: push front, push back,
// pop front, pop back or query (unknown codes act as a query). The result
// channel returns exactly one transfer per operation with the success flag,
// the front and rear words after the operation (-1 when empty), the count
// and the empty and full flags.
// The words live in a 1024-entry ring memory with one write and two read
// ports; head pointer and count are registers. An operation runs through
// execute (pointer update and write), read (front and rear addresses) and
// respond, and the block takes no new operation until the last one has left
// the respond step.
// The result sits in an output register; when the receiver stalls, the next
// operation completes and waits in the respond step until that register is
// free, and op ready stays low meanwhile.
// Reset empties the queue at once (head and count cleared, no memory pass)
// and sets the capacity register to 1024. The user must write capacity through
// the APB port only while no operation is in flight; the block does not enforce it.
module bounded_double_ended_queue_unit
    import bdq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bdq_op_if.sink                op_ch,
    bdq_res_if.source             res_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    bdq_cfg_t cfg;

    logic [1:0]               state_reg, state_next;
    logic [2:0]               op_reg;
    logic signed [WORD_W-1:0] value_reg;
    logic [ADDR_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     ok_reg, ok_next;

    logic                     can_push;
    logic                     can_pop;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rear_addr;
    logic signed [WORD_W-1:0] ring_mem [DEPTH];
    logic signed [WORD_W-1:0] front_rd_reg;
    logic signed [WORD_W-1:0] rear_rd_reg;

    logic                     out_load;
    logic                     out_valid_reg;
    logic                     out_success_reg;
    logic signed [WORD_W-1:0] out_front_reg;
    logic signed [WORD_W-1:0] out_rear_reg;
    logic [CNT_W-1:0]         out_count_reg;
    logic                     out_empty_reg;
    logic                     out_full_reg;

    bdq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign op_ch.ready = (state_reg == ST_IDLE);

    // Sequencer: execute, read, respond.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_ch.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_READ;
            ST_READ: state_next = ST_RESP;
            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Capture the accepted operation.
    always_ff @(posedge clk)
    begin
        if (op_ch.valid && op_ch.ready)
        begin
            op_reg    <= op_ch.op;
            value_reg <= op_ch.value;
        end
    end

    // Pointer and count update, and the store write for pushes.
    assign can_push = (count_reg < cfg.eff_capacity);
    assign can_pop  = (count_reg != '0);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        ok_next    = 1'b1;
        wr_en      = 1'b0;
        wr_addr    = head_reg + count_reg[ADDR_W-1:0];
        case (op_reg)
            OP_PUSH_FRONT:
            begin
                if (can_push)
                begin
                    head_next  = head_reg - ADDR_W'(1);
                    wr_addr    = head_reg - ADDR_W'(1);
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    ok_next = 1'b0;
                end
            end
            OP_PUSH_BACK:
            begin
                if (can_push)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    ok_next = 1'b0;
                end
            end
            OP_POP_FRONT:
            begin
                if (can_pop)
                begin
                    head_next  = head_reg + ADDR_W'(1);
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    ok_next = 1'b0;
                end
            end
            OP_POP_BACK:
            begin
                if (can_pop)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    ok_next = 1'b0;
                end
            end
            default:
            begin
                ok_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EXEC)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
                ok_reg    <= ok_next;
            end
        end
    end

    // Ring memory: the write lands in execute, both ends are read in the read step that follows.
    assign rd_en     = (state_reg == ST_READ);
    assign rear_addr = head_reg + count_reg[ADDR_W-1:0] - ADDR_W'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en && (state_reg == ST_EXEC))
        begin
            ring_mem[wr_addr] <= value_reg;
        end
        if (rd_en)
        begin
            front_rd_reg <= ring_mem[head_reg];
            rear_rd_reg  <= ring_mem[rear_addr];
        end
    end

    // Output register; in the respond step it loads when empty or when its transfer completes.
    assign out_load = (state_reg == ST_RESP) && (!out_valid_reg || res_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_success_reg <= ok_reg;
            out_front_reg   <= can_pop ? front_rd_reg : EMPTY_WORD;
            out_rear_reg    <= can_pop ? rear_rd_reg : EMPTY_WORD;
            out_count_reg   <= count_reg;
            out_empty_reg   <= !can_pop;
            out_full_reg    <= (count_reg >= cfg.eff_capacity);
        end
    end

    assign res_ch.valid       = out_valid_reg;
    assign res_ch.success     = out_success_reg;
    assign res_ch.front_value = out_front_reg;
    assign res_ch.rear_value  = out_rear_reg;
    assign res_ch.entry_count = out_count_reg;
    assign res_ch.is_empty    = out_empty_reg;
    assign res_ch.is_full     = out_full_reg;

endmodule

// ----- hw/rtl/bdq_checker.sv -----
`timescale 1ns / 1ps

module bdq_checker
    import bdq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     op_valid,
    input logic                     op_ready,
    input logic                     res_valid,
    input logic                     res_ready,
    input logic                     success,
    input logic signed [WORD_W-1:0] front_value,
    input logic signed [WORD_W-1:0] rear_value,
    input logic [CNT_W-1:0]         entry_count,
    input logic                     is_empty,
    input logic                     is_full
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn before its transfer");

    // The empty flag agrees with the count.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (is_empty == (entry_count == '0)))
        else $error("empty flag disagrees with count");

    // An empty queue reports -1 at both ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_empty |-> (front_value == EMPTY_WORD) && (rear_value == EMPTY_WORD))
        else $error("empty queue reports a word");

    // The count never exceeds the store depth; an empty, full, failed result has a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (entry_count <= CNT_W'(DEPTH)) && (!is_empty || success || !is_full
            || entry_count == '0))
        else $error("count out of range");

    // Operations are taken one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && op_ready |=> !op_ready)
        else $error("second operation taken while one is in flight");

endmodule

bind bounded_double_ended_queue_unit bdq_checker u_bdq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .op_valid    (op_ch.valid),
    .op_ready    (op_ch.ready),
    .res_valid   (res_ch.valid),
    .res_ready   (res_ch.ready),
    .success     (res_ch.success),
    .front_value (res_ch.front_value),
    .rear_value  (res_ch.rear_value),
    .entry_count (res_ch.entry_count),
    .is_empty    (res_ch.is_empty),
    .is_full     (res_ch.is_full)
);
